### rtl/qmr_pkg.sv
// ----------------------------------------------------------------------------
// qmr_pkg: shared types and constants for the mount rotation core
// Command codes, sequencer states and the sign pattern of the Hamilton product.
// ----------------------------------------------------------------------------
package qmr_pkg;

	localparam int CMD_BITS    = 3;
	localparam int SENSOR_BITS = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_TRANSFORM = 3'd0,
		CMD_SET_KEEP  = 3'd1,
		CMD_SET_IDENT = 3'd2,
		CMD_RESET_ALL = 3'd3,
		CMD_READ      = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDMEM,
		ST_MUL,
		ST_SQR,
		ST_CHK,
		ST_SQRT,
		ST_DIVI,
		ST_DIVS,
		ST_DONE
	} state_t;

	// product term k*4+i is a[i]*b[k^i]; set bit means the term is subtracted
	localparam logic [15:0] TERM_NEG = 16'h428E;

endpackage

### rtl/quaternion_mount_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_mount_rotate_core: per-sensor mounting table and sandwich rotation
// Holds one mounting quaternion per sensor and rotates items by conj(m)*q*m.
// ----------------------------------------------------------------------------
// Usage notes.
// Input channel (in_valid/in_ready) carries command, sensor and a Q2.14
// quaternion; output channel (out_valid/out_ready) carries one result item per
// input item: out_w..out_z and accepted.
// One item is processed at a time; in_ready is high while the sequencer idles.
// Steps per item, from acceptance to the result register loading:
//   transform : two passes of one shared multiplier, 32 products
//   set       : squared norm on the shared multiplier, band check, then
//               the bit-serial square root and divider
//   read, reset all, out-of-range or unknown command : table read, then result
// The table sits in a single synchronous RAM read once per item; a valid bit
// per entry marks written rows, an unset row reads as identity.
// Reset (arst_n low) clears all valid bits, so every mounting is identity at
// once. Reset-all does the same.
// The result is held in an output register; the next item may be accepted
// while it waits. If the receiver still stalls when the next result is ready,
// the sequencer waits in its final state.
// ----------------------------------------------------------------------------
module quaternion_mount_rotate_core
	import qmr_pkg::*;
#(
	parameter int SENSOR_COUNT   = 6,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [CMD_BITS-1:0]              command,
	input  logic [SENSOR_BITS-1:0]           sensor,
	input  logic signed [COMPONENT_BITS-1:0] in_w,
	input  logic signed [COMPONENT_BITS-1:0] in_x,
	input  logic signed [COMPONENT_BITS-1:0] in_y,
	input  logic signed [COMPONENT_BITS-1:0] in_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COMPONENT_BITS-1:0] out_w,
	output logic signed [COMPONENT_BITS-1:0] out_x,
	output logic signed [COMPONENT_BITS-1:0] out_y,
	output logic signed [COMPONENT_BITS-1:0] out_z,
	output logic                             accepted
);

	localparam int CB   = COMPONENT_BITS;
	localparam int FRAC = CB - 2;
	localparam int PW   = 2 * CB;          // product width
	localparam int AW2  = 2 * CB + 2;      // accumulator width
	localparam int SW   = 2 * FRAC + 2;    // square root working width
	localparam int RW   = CB + 1;          // divider remainder width
	localparam int AW   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int CW   = $clog2(CB);

	localparam logic signed [CB-1:0] ONE_Q  = CB'(longint'(1) << FRAC);
	localparam logic signed [CB-1:0] CMAX   = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN   = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] LIMIT  = CB'(longint'(3) << (FRAC - 1));
	localparam logic signed [CB-1:0] NLIMIT = -LIMIT;
	localparam logic signed [AW2-1:0] HALF  = AW2'(longint'(1) << (FRAC - 1));

	// norm band [0.998001, 1.002001] scaled by 2^(2*FRAC)
	localparam logic [63:0] SCALE  = 64'd1 << (2 * FRAC);
	localparam logic [63:0] SC_Q   = SCALE / 64'd1000000;
	localparam logic [63:0] SC_R   = SCALE % 64'd1000000;
	localparam logic [63:0] LO_THR = SC_Q * 64'd998001 + (SC_R * 64'd998001) / 64'd1000000
		+ ((((SC_R * 64'd998001) % 64'd1000000) != 64'd0) ? 64'd1 : 64'd0);
	localparam logic [63:0] HI_THR = SC_Q * 64'd1002001
		+ (SC_R * 64'd1002001) / 64'd1000000;
	localparam logic [AW2-1:0] LO_T = AW2'(LO_THR);
	localparam logic [AW2-1:0] HI_T = AW2'(HI_THR);

	state_t state_q, state_d;

	// item registers
	cmd_t                cmd_q;
	logic [AW-1:0]       addr_q;
	logic                inr_q;
	logic                ok_q;
	logic signed [CB-1:0] q_q [4];
	logic signed [CB-1:0] m_q [4];
	logic signed [CB-1:0] t_q [4];
	logic signed [CB-1:0] r_q [4];
	logic signed [CB-1:0] n_q [4];

	// sequencing
	logic [4:0]    idx_q;
	logic          phase_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    j_q;

	// multiplier pipeline
	logic signed [PW-1:0]  prod_s1;
	logic                  pv_s1;
	logic [3:0]            pidx_s1;
	logic signed [AW2-1:0] acc_q;

	// square root and divider
	logic [SW-1:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [RW-1:0] rem_q;
	logic [CB-1:0] dnum_q, qt_q;

	// mounting table
	logic [4*CB-1:0]         mem [SENSOR_COUNT];
	logic [4*CB-1:0]         rd_q;
	logic [SENSOR_COUNT-1:0] valid_q;

	logic signed [CB-1:0] out_q [4];
	logic                 out_valid_q, acc_out_q;

	logic in_fire, done_go, wr_en, clr_one, clr_all;
	logic [AW-1:0] in_addr;
	logic          in_rng;

	assign in_addr = AW'(sensor);
	assign in_rng  = (32'(sensor) < SENSOR_COUNT);
	assign in_fire = in_valid && in_ready;

	// ---------------- multiplier operand selection ----------------
	logic [1:0]           mi, mk, mbi;
	logic signed [CB-1:0] mul_a, mul_b;
	logic                 mul_neg, mul_issue;
	logic signed [PW-1:0] prod_full;

	always_comb begin
		mi        = idx_q[1:0];
		mk        = idx_q[3:2];
		mbi       = mk ^ mi;
		mul_a     = q_q[mi];
		mul_b     = q_q[mi];
		mul_neg   = 1'b0;
		mul_issue = 1'b0;
		if (state_q == ST_MUL) begin
			mul_issue = !idx_q[4];
			if (!phase_q) begin
				// conj(m) * q : vector part of m negated
				mul_a   = m_q[mi];
				mul_b   = q_q[mbi];
				mul_neg = TERM_NEG[idx_q[3:0]] ^ (mi != 2'd0);
			end else begin
				mul_a   = t_q[mi];
				mul_b   = m_q[mbi];
				mul_neg = TERM_NEG[idx_q[3:0]];
			end
		end else if (state_q == ST_SQR) begin
			mul_issue = !idx_q[2];
		end
		prod_full = mul_a * mul_b;
	end

	// ---------------- accumulate, round, saturate ----------------
	logic signed [AW2-1:0] acc_base, acc_sum, rsh;
	logic signed [CB-1:0]  rnd;

	always_comb begin
		acc_base = (pidx_s1[1:0] == 2'd0) ? '0 : acc_q;
		acc_sum  = acc_base + AW2'(prod_s1);
		rsh      = (acc_sum + HALF) >>> FRAC;
		if (rsh > AW2'(CMAX))
			rnd = CMAX;
		else if (rsh < AW2'(CMIN))
			rnd = CMIN;
		else
			rnd = CB'(rsh);
	end

	// ---------------- validation ----------------
	logic limit_ok, band_ok;

	always_comb begin
		limit_ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (q_q[i] > LIMIT || q_q[i] < NLIMIT)
				limit_ok = 1'b0;
		end
		band_ok = (acc_q >= LO_T) && (acc_q <= HI_T);
	end

	// ---------------- square root step ----------------
	logic [SW-1:0] sq_trial;
	logic          sq_ge;

	assign sq_trial = sq_res_q + sq_bit_q;
	assign sq_ge    = (sq_n_q >= sq_trial);

	// ---------------- divider ----------------
	logic [RW-1:0]        s_div, rtry;
	logic [CB-1:0]        abs_c, qfin;
	logic [PW-1:0]        num;
	logic                 d_ge;
	logic signed [CB-1:0] qsat;

	always_comb begin
		s_div = sq_res_q[RW-1:0];
		abs_c = q_q[j_q][CB-1] ? CB'(-q_q[j_q]) : CB'(q_q[j_q]);
		num   = (PW'(abs_c) << FRAC) + PW'(s_div >> 1);
		rtry  = {rem_q[RW-2:0], dnum_q[CB-1]};
		d_ge  = (rtry >= s_div);
		qfin  = {qt_q[CB-2:0], d_ge};
		if (q_q[j_q][CB-1])
			qsat = (qfin > CB'(CMIN)) ? CMIN : CB'(-qfin);
		else
			qsat = qfin[CB-1] ? CMAX : CB'(qfin);
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_RDMEM;
			end
			ST_RDMEM: begin
				if (inr_q && cmd_q == CMD_TRANSFORM)
					state_d = ST_MUL;
				else if (inr_q && (cmd_q == CMD_SET_KEEP || cmd_q == CMD_SET_IDENT))
					state_d = ST_SQR;
				else
					state_d = ST_DONE;
			end
			ST_MUL: begin
				if (idx_q[4] && phase_q)
					state_d = ST_DONE;
			end
			ST_SQR: begin
				if (idx_q[2])
					state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = (limit_ok && band_ok) ? ST_SQRT : ST_DONE;
			end
			ST_SQRT: begin
				if (cnt_q == '0)
					state_d = ST_DIVI;
			end
			ST_DIVI: begin
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				if (cnt_q == '0)
					state_d = (j_q == 2'd3) ? ST_DONE : ST_DIVI;
			end
			ST_DONE: begin
				if (done_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		done_go  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		wr_en    = done_go && inr_q && ok_q
			&& (cmd_q == CMD_SET_KEEP || cmd_q == CMD_SET_IDENT);
		clr_one  = done_go && inr_q && !ok_q && (cmd_q == CMD_SET_IDENT);
		clr_all  = done_go && (cmd_q == CMD_RESET_ALL);
	end

	// result selection
	logic signed [CB-1:0] res [4];
	logic                 res_acc;

	always_comb begin
		res[0]  = ONE_Q;
		res[1]  = '0;
		res[2]  = '0;
		res[3]  = '0;
		res_acc = 1'b0;
		unique case (cmd_q)
			CMD_TRANSFORM: begin
				res     = inr_q ? r_q : q_q;
				res_acc = inr_q;
			end
			CMD_SET_KEEP, CMD_SET_IDENT: begin
				res_acc = inr_q && ok_q;
				if (inr_q && ok_q)
					res = n_q;
				else if (inr_q && cmd_q == CMD_SET_KEEP)
					res = m_q;
			end
			CMD_RESET_ALL: begin
				res[0]  = '0;
				res_acc = 1'b1;
			end
			CMD_READ: begin
				if (inr_q)
					res = m_q;
				res_acc = inr_q;
			end
			default: begin
				res[0] = '0;
			end
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			j_q         <= '0;
			pv_s1       <= 1'b0;
			ok_q        <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= mul_issue;

			if (in_fire)
				ok_q <= 1'b0;

			if (state_q == ST_RDMEM) begin
				idx_q   <= '0;
				phase_q <= 1'b0;
			end else if (state_q == ST_MUL) begin
				if (idx_q[4]) begin
					idx_q   <= '0;
					phase_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end else if (state_q == ST_SQR) begin
				idx_q <= idx_q + 5'd1;
			end

			if (state_q == ST_CHK) begin
				cnt_q <= CW'(FRAC);
				j_q   <= '0;
			end else if (state_q == ST_SQRT) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (state_q == ST_DIVI) begin
				cnt_q <= CW'(CB - 1);
			end else if (state_q == ST_DIVS) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3)
						ok_q <= 1'b1;
				end
			end

			if (clr_all)
				valid_q <= '0;
			else if (clr_one)
				valid_q[addr_q] <= 1'b0;
			else if (wr_en)
				valid_q[addr_q] <= 1'b1;

			if (done_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= cmd_t'(command);
			addr_q <= in_addr;
			inr_q  <= in_rng;
			q_q[0] <= in_w;
			q_q[1] <= in_x;
			q_q[2] <= in_y;
			q_q[3] <= in_z;
		end

		if (state_q == ST_RDMEM) begin
			for (int i = 0; i < 4; i++)
				m_q[i] <= valid_q[addr_q] ? rd_q[i*CB +: CB]
					: ((i == 0) ? ONE_Q : '0);
		end

		prod_s1 <= mul_neg ? -prod_full : prod_full;
		pidx_s1 <= idx_q[3:0];

		if (pv_s1) begin
			acc_q <= acc_sum;
			if (state_q == ST_MUL && pidx_s1[1:0] == 2'd3) begin
				if (!phase_q)
					t_q[pidx_s1[3:2]] <= rnd;
				else
					r_q[pidx_s1[3:2]] <= rnd;
			end
		end

		if (state_q == ST_CHK) begin
			sq_n_q   <= acc_q[SW-1:0];
			sq_res_q <= '0;
			sq_bit_q <= SW'(1) << (2 * FRAC);
		end else if (state_q == ST_SQRT) begin
			if (sq_ge) begin
				sq_n_q   <= sq_n_q - sq_trial;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end

		if (state_q == ST_DIVI) begin
			rem_q  <= RW'(num[PW-1:CB]);
			dnum_q <= num[CB-1:0];
			qt_q   <= '0;
		end else if (state_q == ST_DIVS) begin
			rem_q  <= d_ge ? (rtry - s_div) : rtry;
			dnum_q <= dnum_q << 1;
			qt_q   <= qfin;
			if (cnt_q == '0)
				n_q[j_q] <= qsat;
		end

		if (done_go) begin
			out_q     <= res;
			acc_out_q <= res_acc;
		end
	end

	// ---------------- mounting table RAM ----------------
	always_ff @(posedge clk) begin
		if (in_fire)
			rd_q <= mem[in_addr];
		if (wr_en)
			mem[addr_q] <= {n_q[3], n_q[2], n_q[1], n_q[0]};
	end

	assign out_valid = out_valid_q;
	assign out_w     = out_q[0];
	assign out_x     = out_q[1];
	assign out_y     = out_q[2];
	assign out_z     = out_q[3];
	assign accepted  = acc_out_q;

	// ---------------- assertions ----------------
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the final state");

	a_reset_all_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_all |=> (valid_q == '0))
		else $error("reset-all left a written entry");

	a_prod_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> (state_q == ST_MUL || state_q == ST_SQR))
		else $error("product pending outside multiply states");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVI || state_q == ST_DIVS) |-> (sq_res_q != '0))
		else $error("division by zero norm");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the quaternion mount rotation core
// Directed and random commands into the core; a mounting-table predictor
// forecasts each result item, and a scoreboard checks the outputs in order.
// ----------------------------------------------------------------------------

// Scoreboard: the mounting table, the arithmetic and the queue of expected items.
class mount_scoreboard;
	typedef struct {
		logic signed [15:0] w, x, y, z;
		logic               ok;
	} rot_item_t;

	logic signed [15:0] mount [6][4];
	rot_item_t          pending [$];
	int                 errors;

	function new();
		errors = 0;
		clear_mounts();
	endfunction

	function void clear_mounts();
		for (int s = 0; s < 6; s++) begin
			mount[s][0] = 16'sd16384;
			mount[s][1] = 0;
			mount[s][2] = 0;
			mount[s][3] = 0;
		end
	endfunction

	static function logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// Hamilton product; rounding to nearest with ties up equals floor(sum + half)
	static function void hamilton(input longint a [4], input longint b [4],
		output longint r [4]);
		longint acc;
		int     bi;
		for (int k = 0; k < 4; k++) begin
			acc = 0;
			for (int i = 0; i < 4; i++) begin
				bi = k ^ i;
				if (qmr_pkg::TERM_NEG[k*4+i]) acc -= a[i] * b[bi];
				else acc += a[i] * b[bi];
			end
			r[k] = clamp16((acc + 8192) >>> 14);
		end
	endfunction

	static function longint isqrt(longint n);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return r;
	endfunction

	// component limit and squared-norm band check, then normalisation
	static function bit check_mount(input longint c [4], output longint o [4]);
		longint n2, s, a, v, lo_thr, hi_thr;
		n2 = 0;
		for (int i = 0; i < 4; i++) begin
			a = c[i] < 0 ? -c[i] : c[i];
			if (a > 24576) return 0;
			n2 += a * a;
		end
		lo_thr = ((64'd1 << 28) * 998001 + 999999) / 1000000;
		hi_thr = ((64'd1 << 28) * 1002001) / 1000000;
		if (n2 < lo_thr || n2 > hi_thr) return 0;
		s = isqrt(n2);
		for (int i = 0; i < 4; i++) begin
			a = c[i] < 0 ? -c[i] : c[i];
			v = (a * 16384 + s / 2) / s;
			o[i] = clamp16(c[i] < 0 ? -v : v);
		end
		return 1;
	endfunction

	function void note_command(logic [2:0] cmd, logic [2:0] sid,
		logic signed [15:0] qw, qx, qy, qz);
		longint    q [4], m [4], cj [4], t [4], r [4];
		rot_item_t e;
		bit        in_range;
		in_range = sid < 6;
		q[0] = qw; q[1] = qx; q[2] = qy; q[3] = qz;
		for (int i = 0; i < 4; i++) r[i] = 0;
		e.ok = 1;
		case (cmd)
			qmr_pkg::CMD_TRANSFORM: begin
				if (!in_range) begin
					r = q;
					e.ok = 0;
				end else begin
					for (int i = 0; i < 4; i++) m[i] = mount[sid][i];
					cj[0] = m[0]; cj[1] = -m[1]; cj[2] = -m[2]; cj[3] = -m[3];
					hamilton(cj, q, t);
					hamilton(t, m, r);
				end
			end
			qmr_pkg::CMD_SET_KEEP, qmr_pkg::CMD_SET_IDENT: begin
				if (!in_range) begin
					r[0] = 16384;
					e.ok = 0;
				end else begin
					if (check_mount(q, t)) begin
						for (int i = 0; i < 4; i++) mount[sid][i] = 16'(t[i]);
					end else begin
						e.ok = 0;
						if (cmd == qmr_pkg::CMD_SET_IDENT) begin
							mount[sid][0] = 16384;
							for (int i = 1; i < 4; i++) mount[sid][i] = 0;
						end
					end
					for (int i = 0; i < 4; i++) r[i] = mount[sid][i];
				end
			end
			qmr_pkg::CMD_RESET_ALL: clear_mounts();
			qmr_pkg::CMD_READ: begin
				if (!in_range) begin
					r[0] = 16384;
					e.ok = 0;
				end else begin
					for (int i = 0; i < 4; i++) r[i] = mount[sid][i];
				end
			end
			default: e.ok = 0;
		endcase
		e.w = 16'(r[0]); e.x = 16'(r[1]); e.y = 16'(r[2]); e.z = 16'(r[3]);
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [15:0] w, x, y, z, logic ok);
		rot_item_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result item %0d %0d %0d %0d acc %0b",
				$time, w, x, y, z, ok);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (w !== e.w) begin
			$display("%0t: out_w expected %0d got %0d", $time, e.w, w);
			errors++;
		end
		if (x !== e.x) begin
			$display("%0t: out_x expected %0d got %0d", $time, e.x, x);
			errors++;
		end
		if (y !== e.y) begin
			$display("%0t: out_y expected %0d got %0d", $time, e.y, y);
			errors++;
		end
		if (z !== e.z) begin
			$display("%0t: out_z expected %0d got %0d", $time, e.z, z);
			errors++;
		end
		if (ok !== e.ok) begin
			$display("%0t: accepted expected %0b got %0b", $time, e.ok, ok);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import qmr_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [2:0]         command = 0;
	logic [2:0]         sensor = 0;
	logic signed [15:0] in_w = 0, in_x = 0, in_y = 0, in_z = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] out_w, out_x, out_y, out_z;
	logic               accepted;

	mount_scoreboard sb;
	longint          cycle_count = 0;
	bit              idle_off = 0;   // set during the stretch with no idling

	// the receiver stalls briefly, so this limit is ample
	localparam longint CYCLE_LIMIT = 1000000;

	always #4 clk = ~clk;

	quaternion_mount_rotate_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .sensor(sensor),
		.in_w(in_w), .in_x(in_x), .in_y(in_y), .in_z(in_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.accepted(accepted)
	);

	// accepted inputs feed the predictor, accepted results the checker
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_command(command, sensor, in_w, in_x, in_y, in_z);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_w, out_x, out_y, out_z, accepted);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: stalls at random about 8 percent of the time
	always @(negedge clk)
		out_ready <= idle_off || ($urandom_range(99) >= 8);

	// drive one item; valid stays up until the handshake and is dropped
	// only by an idle cycle or at the end of the run
	task automatic send_item(logic [2:0] cmd, logic [2:0] sid,
		logic signed [15:0] qw, qx, qy, qz);
		while (!idle_off && $urandom_range(99) < 8) begin
			in_valid <= 0;
			@(negedge clk);
		end
		command <= cmd; sensor <= sid;
		in_w <= qw; in_x <= qx; in_y <= qy; in_z <= qz;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// a near-unit mounting, sometimes nudged just outside the band
	task automatic send_mount(logic [2:0] cmd, logic [2:0] sid);
		int          c [4];
		int          k;
		logic signed [15:0] v [4];
		for (int i = 0; i < 4; i++) c[i] = $urandom_range(16384);
		k = $urandom_range(3);
		// scale so that the largest part keeps the norm close to one
		for (int i = 0; i < 4; i++) c[i] = c[i] / 2;
		c[k] = 0;
		begin
			longint rest, need;
			rest = 0;
			for (int i = 0; i < 4; i++) rest += c[i] * c[i];
			need = (longint'(1) << 28) - rest;
			if (need < 0) need = 0;
			c[k] = int'(sb.isqrt(need)) + int'($urandom_range(40)) - 20;
		end
		for (int i = 0; i < 4; i++) v[i] = 16'($urandom_range(1) ? -c[i] : c[i]);
		send_item(cmd, sid, v[0], v[1], v[2], v[3]);
	endtask

	initial begin
		int          pick;
		logic [2:0]  sid;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, each command, each special case
		send_item(CMD_READ, 0, 0, 0, 0, 0);
		send_item(CMD_TRANSFORM, 1, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_item(CMD_SET_KEEP, 2, 0, 16384, 0, 0);
		send_item(CMD_TRANSFORM, 2, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
		send_item(CMD_SET_KEEP, 2, 16'sh8000, 0, 0, 0);
		send_item(CMD_READ, 2, 0, 0, 0, 0);
		send_item(CMD_SET_IDENT, 2, 100, 0, 0, 0);
		send_item(CMD_READ, 2, 0, 0, 0, 0);
		send_item(CMD_SET_KEEP, 3, 11585, 0, 11585, 0);
		send_item(CMD_SET_KEEP, 4, 16384, 16384, 16384, 16384);
		send_item(CMD_SET_IDENT, 5, 8192, 8192, 8192, 8192);
		send_item(CMD_SET_IDENT, 5, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_item(CMD_SET_KEEP, 0, 16'sd16360, 0, 0, 0); // just under the band
		send_item(CMD_SET_KEEP, 0, -16'sd16401, 0, 0, 0); // just over the band
		send_item(CMD_TRANSFORM, 6, 1, -2, 3, -4);       // out-of-range sensor
		send_item(CMD_SET_KEEP, 7, 16384, 0, 0, 0);
		send_item(CMD_SET_IDENT, 6, 16384, 0, 0, 0);
		send_item(CMD_READ, 7, 0, 0, 0, 0);
		send_item(3'd5, 1, 1, 1, 1, 1);                  // unknown commands
		send_item(3'd7, 7, -1, -1, -1, -1);
		send_item(CMD_TRANSFORM, 3, 16'sh7fff, 0, 0, 16'sh8000);
		send_item(CMD_RESET_ALL, 6, 0, 0, 0, 0);
		send_item(CMD_READ, 3, 0, 0, 0, 0);

		// random: mostly mount writes and transforms, some noise
		for (int n = 0; n < 1550; n++) begin
			idle_off = (n >= 600 && n < 800);
			pick = $urandom_range(99);
			sid = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
			if (pick < 45)
				send_item(CMD_TRANSFORM, sid, rnd16(), rnd16(), rnd16(), rnd16());
			else if (pick < 65)
				send_mount($urandom_range(1) ? CMD_SET_KEEP : CMD_SET_IDENT, sid);
			else if (pick < 72)
				send_item($urandom_range(1) ? CMD_SET_KEEP : CMD_SET_IDENT, sid,
					rnd16(), rnd16(), rnd16(), rnd16());
			else if (pick < 90)
				send_item(CMD_READ, sid, rnd16(), rnd16(), rnd16(), rnd16());
			else if (pick < 94)
				send_item(CMD_RESET_ALL, sid, rnd16(), rnd16(), rnd16(), rnd16());
			else
				send_item(3'($urandom_range(7, 5)), sid, rnd16(), rnd16(), rnd16(), rnd16());
		end
		in_valid <= 0;
		idle_off = 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
